// File: design/sacd_pkg.sv
// Shared types and constants of the set-associative cache directory.
`default_nettype none

package sacd_pkg;

    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 32;
    localparam int ST_W    = 2;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_INVAL = 2'd2;

    localparam logic [ST_W-1:0] ST_INVALID = 2'd0;
    localparam logic [ST_W-1:0] ST_EXCL    = 2'd1;
    localparam logic [ST_W-1:0] ST_MOD     = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    typedef struct packed {
        logic              wr;
        logic              adv;
        logic              miss;
        logic              hit;
        logic [1:0]        way;
        logic [ST_W-1:0]   line_state;
        logic              victim_valid;
        logic [ADDR_W-1:0] victim_addr;
    } res_t;

endpackage

`default_nettype wire

// File: design/set_assoc_lru_cache_directory_top.sv
// Top level of the set-associative cache directory with LRU replacement.
//
// An access is taken when start is high and busy is low. In that cycle the
// set's row is read from the directory RAM; in the update state the block
// compares tags, picks the way and writes the row back if the access changed
// it. The result appears with done high for one cycle on the cycle after the
// update, which is also the first cycle busy is low again, so a new access
// can be taken in that cycle. The RAM has a single, registered read port.
// After reset the block clears the directory one set per cycle and holds busy
// high until every set is clear, taking no access before that. Results cannot
// be stalled; the receiver must take each one in the cycle done is high.
`default_nettype none

module set_assoc_lru_cache_directory_top
    import sacd_pkg::*;
#(
    parameter int SET_BITS    = 6,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        func,
    input  wire logic [ADDR_W-1:0] addr,
    output logic                   done,
    output logic                   hit,
    output logic [1:0]             way,
    output logic [1:0]             line_state,
    output logic                   victim_valid,
    output logic [ADDR_W-1:0]      victim_addr,
    output logic [31:0]            miss_count
);

    localparam int TAG_W  = ADDR_W - SET_BITS - OFFSET_BITS;
    localparam int ENT_W  = ST_W + TAG_W + STAMP_W;
    localparam int ROW_W  = WAYS * ENT_W;
    localparam int SET_IW = (SET_BITS > 0) ? SET_BITS : 1;
    localparam logic [SET_IW-1:0] LAST_SET = SET_IW'((64'd1 << SET_BITS) - 64'd1);

    state_t state_reg, state_next;
    logic [SET_IW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [1:0]         func_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [31:0]        misses_reg, misses_next;
    logic               done_reg, done_next;
    logic               hit_reg;
    logic [1:0]         way_reg;
    logic [1:0]         line_state_reg;
    logic               victim_valid_reg;
    logic [ADDR_W-1:0]  victim_addr_reg;

    logic               accept;
    logic [SET_IW-1:0]  set_in;
    logic [SET_IW-1:0]  set_held;
    logic               rd_en;
    logic               wr_en;
    logic [SET_IW-1:0]  wr_addr;
    logic [ROW_W-1:0]   wr_data;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   row_next;
    res_t               res;

    generate
        if (SET_BITS > 0)
        begin : g_set
            assign set_in   = addr[OFFSET_BITS +: SET_IW];
            assign set_held = addr_reg[OFFSET_BITS +: SET_IW];
        end
        else
        begin : g_noset
            assign set_in   = '0;
            assign set_held = '0;
        end
    endgenerate

    sacd_ram #(
        .WIDTH      (ROW_W),
        .DEPTH_BITS (SET_IW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (set_in),
        .rd_data (row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    sacd_lookup #(
        .SET_BITS    (SET_BITS),
        .WAYS        (WAYS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lookup (
        .func     (func_reg),
        .addr     (addr_reg),
        .stamp    (stamp_reg),
        .row      (row),
        .row_next (row_next),
        .res      (res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_SET)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Outputs of the sequencer and the next values of its counters.
    always_comb
    begin
        busy         = (state_reg != S_IDLE);
        accept       = (state_reg == S_IDLE) && start;
        rd_en        = accept;
        wr_en        = 1'b0;
        wr_addr      = set_held;
        wr_data      = row_next;
        clr_cnt_next = clr_cnt_reg;
        stamp_next   = stamp_reg;
        misses_next  = misses_reg;
        done_next    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_LOOK:
            begin
                wr_en       = res.wr;
                stamp_next  = stamp_reg + STAMP_W'(res.adv);
                misses_next = misses_reg + 32'(res.miss);
                done_next   = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            stamp_reg   <= '0;
            misses_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            stamp_reg   <= stamp_next;
            misses_reg  <= misses_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            addr_reg <= addr;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg          <= res.hit;
            way_reg          <= res.way;
            line_state_reg   <= res.line_state;
            victim_valid_reg <= res.victim_valid;
            victim_addr_reg  <= res.victim_addr;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign way          = way_reg;
    assign line_state   = line_state_reg;
    assign victim_valid = victim_valid_reg;
    assign victim_addr  = victim_addr_reg;
    assign miss_count   = misses_reg;

    a_done_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_LOOK))
        else $error("result beat without a preceding update cycle");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy)
        else $error("access could be taken during the clearing pass");

    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit && ((func_reg == FUNC_READ) || (func_reg == FUNC_WRITE)))
        |-> (misses_reg == $past(misses_reg) + 32'd1))
        else $error("miss not counted exactly once");

    a_victim_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && victim_valid) |-> (!hit && (line_state == ST_EXCL)))
        else $error("eviction reported on a hit or without a fill");

endmodule

`default_nettype wire

// File: design/sacd_ram.sv
// Directory RAM: one row per set, one write port, one registered read port.
`default_nettype none

module sacd_ram #(
    parameter int WIDTH      = 64,
    parameter int DEPTH_BITS = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [DEPTH_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]      rd_data,
    input  wire logic                  wr_en,
    input  wire logic [DEPTH_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data
);

    logic [WIDTH-1:0] mem [1 << DEPTH_BITS];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/sacd_lookup.sv
// Tag compare, victim choice and row update for one set of the directory.
`default_nettype none

module sacd_lookup
    import sacd_pkg::*;
#(
    parameter int SET_BITS    = 6,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 6
) (
    input  wire logic [1:0]                func,
    input  wire logic [ADDR_W-1:0]         addr,
    input  wire logic [STAMP_W-1:0]        stamp,
    input  wire logic [WAYS*(ST_W+ADDR_W-SET_BITS-OFFSET_BITS+STAMP_W)-1:0] row,
    output logic      [WAYS*(ST_W+ADDR_W-SET_BITS-OFFSET_BITS+STAMP_W)-1:0] row_next,
    output res_t                           res
);

    localparam int TAG_W = ADDR_W - SET_BITS - OFFSET_BITS;
    localparam int ENT_W = ST_W + TAG_W + STAMP_W;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LVLS  = (WAYS > 1) ? $clog2(WAYS) : 0;
    localparam int NPAD  = 1 << LVLS;
    localparam logic [ADDR_W-1:0] SET_MASK =
        ADDR_W'(((64'd1 << SET_BITS) - 64'd1) << OFFSET_BITS);

    logic [ST_W-1:0]    ent_st  [WAYS];
    logic [TAG_W-1:0]   ent_tag [WAYS];
    logic [STAMP_W-1:0] ent_ts  [WAYS];
    logic [WAYS-1:0]    match;
    logic [WAYS-1:0]    empty;
    logic [TAG_W-1:0]   tag_in;
    logic [WAY_W-1:0]   match_way;
    logic [WAY_W-1:0]   empty_way;

    // Tournament over last-use times; the left entry wins ties, so the
    // lowest-numbered way with the smallest time comes out on top.
    logic [STAMP_W-1:0] tv [LVLS+1][NPAD];
    logic [WAY_W-1:0]   ti [LVLS+1][NPAD];

    assign tag_in = addr[ADDR_W-1 -: TAG_W];

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            ent_ts[w]  = row[w*ENT_W +: STAMP_W];
            ent_tag[w] = row[w*ENT_W + STAMP_W +: TAG_W];
            ent_st[w]  = row[w*ENT_W + STAMP_W + TAG_W +: ST_W];
            empty[w]   = (ent_st[w] == ST_INVALID);
            match[w]   = !empty[w] && (ent_tag[w] == tag_in);
        end
    end

    always_comb
    begin
        match_way = '0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                match_way = WAY_W'(w);
            end
            if (empty[w])
            begin
                empty_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NPAD; i++)
        begin
            tv[0][i] = (i < WAYS) ? ent_ts[i] : '1;
            ti[0][i] = WAY_W'(i);
        end
        for (int lv = 0; lv < LVLS; lv++)
        begin
            for (int i = 0; i < NPAD; i++)
            begin
                if (i < (NPAD >> (lv + 1)))
                begin
                    if (tv[lv][2*i+1] < tv[lv][2*i])
                    begin
                        tv[lv+1][i] = tv[lv][2*i+1];
                        ti[lv+1][i] = ti[lv][2*i+1];
                    end
                    else
                    begin
                        tv[lv+1][i] = tv[lv][2*i];
                        ti[lv+1][i] = ti[lv][2*i];
                    end
                end
                else
                begin
                    tv[lv+1][i] = '1;
                    ti[lv+1][i] = '0;
                end
            end
        end
    end

    always_comb
    begin
        logic [WAY_W-1:0] pick;
        logic [ST_W-1:0]  st_new;
        logic [4:0]       way_x;

        row_next = row;
        res      = '0;
        pick     = '0;
        st_new   = ST_INVALID;
        case (func)
            FUNC_READ, FUNC_WRITE:
            begin
                res.adv = 1'b1;
                res.wr  = 1'b1;
                if (|match)
                begin
                    pick   = match_way;
                    st_new = ent_st[match_way];
                    if ((func == FUNC_WRITE) && (st_new == ST_EXCL))
                    begin
                        st_new = ST_MOD;
                    end
                    res.hit = 1'b1;
                    row_next[match_way*ENT_W +: ENT_W] =
                        {st_new, ent_tag[match_way], stamp};
                end
                else
                begin
                    res.miss = 1'b1;
                    st_new   = ST_EXCL;
                    if (|empty)
                    begin
                        pick = empty_way;
                    end
                    else
                    begin
                        pick             = ti[LVLS][0];
                        res.victim_valid = 1'b1;
                        res.victim_addr  =
                            (ADDR_W'(ent_tag[pick]) << (OFFSET_BITS + SET_BITS)) |
                            (addr & SET_MASK);
                    end
                    row_next[pick*ENT_W +: ENT_W] = {ST_EXCL, tag_in, stamp};
                end
            end
            FUNC_INVAL:
            begin
                if (|match)
                begin
                    pick    = match_way;
                    res.hit = 1'b1;
                    res.wr  = 1'b1;
                    row_next[match_way*ENT_W + STAMP_W + TAG_W +: ST_W] = ST_INVALID;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        way_x          = {{(5 - WAY_W){1'b0}}, pick};
        res.way        = way_x[1:0];
        res.line_state = st_new;
    end

endmodule

`default_nettype wire

// File: bench/set_assoc_lru_cache_directory_top_tb.sv
// Self-checking testbench of the set-associative LRU cache directory top level.
`default_nettype none

module set_assoc_lru_cache_directory_top_tb
    import sacd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_W        = 6;
    localparam int OFF_W        = 6;
    localparam int TAG_W        = ADDR_W - SET_W - OFF_W;
    localparam int SETS         = 1 << SET_W;
    localparam int NWAYS        = 4;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int ACCESSES     = 1650;
    localparam int CALM_TAIL    = 250;
    localparam int DRAIN_CYCLES = 8;
    // Covers the clearing pass after reset, the longest sender gap and the access latency.
    localparam int STALL_LIMIT  = 2000;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [1:0]        way;
        logic [ST_W-1:0]   line_state;
        logic              victim_valid;
        logic [ADDR_W-1:0] victim_addr;
        logic [31:0]       miss_count;
    } dir_result_t;

    typedef struct {
        logic [1:0]        f;
        logic [ADDR_W-1:0] a;
        bit                typed;
        dir_result_t       r;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
    logic              done;
    logic              hit;
    logic [1:0]        way;
    logic [1:0]        line_state;
    logic              victim_valid;
    logic [ADDR_W-1:0] victim_addr;
    logic [31:0]       miss_count;

    // Shadow copy of the directory.
    logic [TAG_W-1:0]  shadow_tag   [SETS][NWAYS];
    logic [ST_W-1:0]   shadow_state [SETS][NWAYS];
    logic [31:0]       shadow_lru   [SETS][NWAYS];
    logic [31:0]       shadow_stamp;
    logic [31:0]       shadow_misses;

    dir_result_t       pending_results [$];
    plan_row_t         plan [$];
    dir_result_t       want_res;
    dir_result_t       next_exp;
    bit                next_typed;
    int                accepted;
    int                mismatches;
    int                quiet_cycles;
    int                n_hits;
    int                n_evictions;
    int                n_clears;
    bit                idling_on;
    logic [SET_W-1:0]  hot_set [4];
    logic [TAG_W-1:0]  tag_pool [6];

    set_assoc_lru_cache_directory_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .addr         (addr),
        .done         (done),
        .hit          (hit),
        .way          (way),
        .line_state   (line_state),
        .victim_valid (victim_valid),
        .victim_addr  (victim_addr),
        .miss_count   (miss_count)
    );

    always #(CLK_HALF) clk = ~clk;

    // Applies one access to the shadow directory and returns what the block should report.
    function automatic dir_result_t lookup_and_update(input logic [1:0] f,
                                                      input logic [ADDR_W-1:0] a);
        dir_result_t      r;
        logic [SET_W-1:0] s;
        logic [TAG_W-1:0] t;
        int               match;
        int               pick;
        int               w;
        logic [31:0]      oldest;
        begin
            r      = '0;
            s      = a[OFF_W +: SET_W];
            t      = a[ADDR_W-1 -: TAG_W];
            match  = -1;
            pick   = -1;
            oldest = '0;
            for (w = 0; w < NWAYS; w++)
                if (match < 0 && shadow_state[s][w] != ST_INVALID && shadow_tag[s][w] == t)
                    match = w;
            if (f == FUNC_READ || f == FUNC_WRITE)
            begin
                if (match >= 0)
                begin
                    shadow_lru[s][match] = shadow_stamp;
                    if (f == FUNC_WRITE && shadow_state[s][match] == ST_EXCL)
                        shadow_state[s][match] = ST_MOD;
                    r.hit        = 1'b1;
                    r.way        = match[1:0];
                    r.line_state = shadow_state[s][match];
                end
                else
                begin
                    shadow_misses++;
                    for (w = 0; w < NWAYS; w++)
                        if (pick < 0 && shadow_state[s][w] == ST_INVALID)
                            pick = w;
                    if (pick < 0)
                    begin
                        // Full set: the oldest way goes, the lowest-numbered one on a tie.
                        for (w = 0; w < NWAYS; w++)
                            if (w == 0 || shadow_lru[s][w] < oldest)
                            begin
                                oldest = shadow_lru[s][w];
                                pick   = w;
                            end
                        r.victim_valid = 1'b1;
                        r.victim_addr  = {shadow_tag[s][pick], s, {OFF_W{1'b0}}};
                    end
                    shadow_tag[s][pick]   = t;
                    shadow_state[s][pick] = ST_EXCL;
                    shadow_lru[s][pick]   = shadow_stamp;
                    r.way        = pick[1:0];
                    r.line_state = ST_EXCL;
                end
                shadow_stamp++;
            end
            else if (f == FUNC_INVAL && match >= 0)
            begin
                shadow_state[s][match] = ST_INVALID;
                r.hit = 1'b1;
                r.way = match[1:0];
            end
            r.miss_count = shadow_misses;
            return r;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        begin
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        end
    endfunction

    function automatic void add_row(input logic [1:0] f, input logic [ADDR_W-1:0] a,
                                    input bit typed, input dir_result_t r);
        plan_row_t row;
        begin
            row.f     = f;
            row.a     = a;
            row.typed = typed;
            row.r     = r;
            plan.push_back(row);
        end
    endfunction

    // Results are checked before the new access is taken, since one cannot
    // come back in the same cycle that it was accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat arrived with no access outstanding");
                    mismatches++;
                end
                else
                begin
                    want_res = pending_results.pop_front();
                    check_field("hit", want_res.hit, hit);
                    check_field("way", want_res.way, way);
                    check_field("line_state", want_res.line_state, line_state);
                    check_field("victim_valid", want_res.victim_valid, victim_valid);
                    check_field("victim_addr", want_res.victim_addr, victim_addr);
                    check_field("miss_count", want_res.miss_count, miss_count);
                end
                if (hit && line_state != ST_INVALID)
                    n_hits++;
                if (hit && line_state == ST_INVALID)
                    n_clears++;
                if (victim_valid)
                    n_evictions++;
            end
            if (start && !busy)
            begin
                want_res = lookup_and_update(func, addr);
                if (next_typed)
                    want_res = next_exp;
                pending_results.push_back(want_res);
                accepted++;
            end
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("set_assoc_lru_cache_directory_top regression: fail");
                $finish;
            end
        end
    end

    task automatic sender_pause();
        begin
            if (idling_on && $urandom_range(0, 3) == 0)
            begin
                start = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    endtask

    // Presents one access beat and holds it until the block takes it.
    task automatic issue(input logic [1:0] f, input logic [ADDR_W-1:0] a, input bit typed,
                         input dir_result_t r);
        int prior_count;
        begin
            prior_count = accepted;
            start       = 1'b1;
            func        = f;
            addr        = a;
            next_typed  = typed;
            next_exp    = r;
            do @(negedge clk); while (accepted == prior_count);
        end
    endtask

    initial
    begin
        int               k;
        int               real_items;
        int               pct;
        logic [1:0]       f;
        logic [SET_W-1:0] s;
        logic [TAG_W-1:0] t;

        start         = 1'b0;
        func          = FUNC_READ;
        addr          = '0;
        rst_n         = 1'b0;
        next_typed    = 1'b0;
        next_exp      = '0;
        accepted      = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        n_hits        = 0;
        n_evictions   = 0;
        n_clears      = 0;
        shadow_stamp  = '0;
        shadow_misses = '0;
        idling_on     = 1'b1;
        for (int i = 0; i < SETS; i++)
            for (int j = 0; j < NWAYS; j++)
            begin
                shadow_tag[i][j]   = '0;
                shadow_state[i][j] = ST_INVALID;
                shadow_lru[i][j]   = '0;
            end

        // Directed part: extremes, every operation and the special cases.
        add_row(FUNC_READ,  32'h0000_0000, 1, {1'b0, 2'd0, ST_EXCL,    1'b0, 32'd0, 32'd1});
        add_row(FUNC_WRITE, 32'h0000_0000, 1, {1'b1, 2'd0, ST_MOD,     1'b0, 32'd0, 32'd1});
        add_row(FUNC_INVAL, 32'hFFFF_FFFF, 1, {1'b0, 2'd0, ST_INVALID, 1'b0, 32'd0, 32'd1});
        add_row(FUNC_NONE,  32'hFFFF_FFFF, 1, {1'b0, 2'd0, ST_INVALID, 1'b0, 32'd0, 32'd1});
        add_row(FUNC_WRITE, 32'hFFFF_FFFF, 1, {1'b0, 2'd0, ST_EXCL,    1'b0, 32'd0, 32'd2});
        add_row(FUNC_WRITE, 32'hFFFF_FFC0, 1, {1'b1, 2'd0, ST_MOD,     1'b0, 32'd0, 32'd2});
        add_row(FUNC_INVAL, 32'hFFFF_FFFF, 1, {1'b1, 2'd0, ST_INVALID, 1'b0, 32'd0, 32'd2});
        add_row(FUNC_READ,  32'h0000_1000, 0, '0);
        add_row(FUNC_WRITE, 32'h0000_2000, 0, '0);
        add_row(FUNC_READ,  32'h0000_303F, 0, '0);
        add_row(FUNC_READ,  32'h0000_0020, 0, '0);
        add_row(FUNC_READ,  32'h0000_4000, 0, '0);
        add_row(FUNC_WRITE, 32'h0000_1000, 0, '0);
        add_row(FUNC_INVAL, 32'h0000_2010, 0, '0);
        add_row(FUNC_READ,  32'h0000_5000, 0, '0);
        add_row(FUNC_INVAL, 32'h0000_9000, 0, '0);
        add_row(FUNC_WRITE, 32'hAAAA_AAAA, 0, '0);
        add_row(FUNC_READ,  32'h5555_5555, 0, '0);
        add_row(FUNC_NONE,  32'h0000_0000, 0, '0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            sender_pause();
            issue(plan[i].f, plan[i].a, plan[i].typed, plan[i].r);
        end

        // A few hot sets and a pool of six tags keep the sets full, so hits,
        // evictions and clears all occur often.
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            tag_pool[i] = TAG_W'($urandom());
        for (int i = 0; i < 4; i++)
            hot_set[i] = SET_W'($urandom());

        real_items = 0;
        while (real_items < ACCESSES)
        begin
            pct = $urandom_range(0, 99);
            if (pct < 40)
                f = FUNC_READ;
            else if (pct < 75)
                f = FUNC_WRITE;
            else if (pct < 95)
                f = FUNC_INVAL;
            else
                f = FUNC_NONE;
            if ($urandom_range(0, 3) != 0)
                s = hot_set[$urandom_range(0, 3)];
            else
                s = SET_W'($urandom());
            if ($urandom_range(0, 6) != 0)
                t = tag_pool[$urandom_range(0, 5)];
            else
                t = TAG_W'($urandom());
            if (f != FUNC_NONE)
                real_items++;
            k = real_items / 200;
            idling_on = (real_items < ACCESSES - CALM_TAIL) && (k % 4 != 3);
            sender_pause();
            issue(f, {t, s, OFF_W'($urandom())}, 1'b0, '0);
        end
        start = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d accesses: %0d hits, %0d evictions, %0d invalidations cleared.",
                 accepted, n_hits, n_evictions, n_clears);
        $display("Final miss count %0d, timestamp %0d.", shadow_misses, shadow_stamp);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("set_assoc_lru_cache_directory_top regression: pass");
        else
            $display("set_assoc_lru_cache_directory_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: set_assoc_lru_cache_directory_top.f
design/sacd_pkg.sv
design/sacd_ram.sv
design/sacd_lookup.sv
design/set_assoc_lru_cache_directory_top.sv
bench/set_assoc_lru_cache_directory_top_tb.sv
